// ===== sv/itm_pkg.sv =====
package itm_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 13;
  localparam int DIM_BITS   = 12;
  localparam int LABEL_W    = 8;
  localparam int MISS_W     = 4;
  localparam int Q_BITS     = 16;
  localparam int ALPHA_W    = Q_BITS + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = ALPHA_W;

  // fixed point widths of the smoothed state
  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int SIZE_W = DIM_BITS + FRAC_BITS;
  localparam int VEL_W  = POS_W + 1;
  localparam int EMA_W  = VEL_W + 2;
  localparam int PROD_W = EMA_W + ALPHA_W + 2;

  // overlap arithmetic
  localparam int AREA_W = 2 * DIM_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int THR_W  = UNI_W + ALPHA_W;
  localparam int CMP_W  = AREA_W + UNI_W;

  // ghost prediction
  localparam int GP_W = VEL_W + MISS_W + 1;
  localparam int GS_W = GP_W + 1;

  localparam int STEP_W    = 3;
  localparam int EMA_OPS   = 6;
  localparam int DRAIN_CYC = 6;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << Q_BITS;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(32768);
  localparam logic [ALPHA_W-1:0] THR_RST   = ALPHA_W'(19661);
  localparam logic [MISS_W-1:0]  MISS_RST  = MISS_W'(5);

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (Q_BITS - 1);
  localparam logic signed [GS_W-1:0]   GS_HALF   = GS_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [GS_W-1:0]   POS_MAX   = GS_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [GS_W-1:0]   POS_MIN   = -POS_MAX - GS_W'(1);
  localparam logic [SIZE_W:0]          SIZE_HALF = (SIZE_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [SIZE_W:0]          DIM_MAX   = (SIZE_W + 1)'((1 << DIM_BITS) - 1);

  // smoothing operation order
  localparam logic [STEP_W-1:0] EOP_VX = 3'd0;
  localparam logic [STEP_W-1:0] EOP_VY = 3'd1;
  localparam logic [STEP_W-1:0] EOP_PX = 3'd2;
  localparam logic [STEP_W-1:0] EOP_PY = 3'd3;
  localparam logic [STEP_W-1:0] EOP_SW = 3'd4;
  localparam logic [STEP_W-1:0] EOP_SH = 3'd5;

  typedef enum logic [1:0] {
    KIND_MATCH     = 2'd0,
    KIND_NEW       = 2'd1,
    KIND_GHOST     = 2'd2,
    KIND_UNTRACKED = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA   = 2'd0,
    CFG_IOU     = 2'd1,
    CFG_MAXMISS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LABEL_W-1:0]           label;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [DIM_BITS-1:0]          bw;
    logic [DIM_BITS-1:0]          bh;
    logic signed [POS_W-1:0]      px;
    logic signed [POS_W-1:0]      py;
    logic [SIZE_W-1:0]            sw;
    logic [SIZE_W-1:0]            sh;
    logic signed [VEL_W-1:0]      vx;
    logic signed [VEL_W-1:0]      vy;
    logic [MISS_W-1:0]            miss;
  } track_t;

  typedef struct packed {
    logic              acc;
    logic              scan_start;
    logic              scan_rd;
    logic              rd;
    logic [IDX_W-1:0]  addr;
    logic              ema_en;
    logic [STEP_W-1:0] ema_step;
    logic              match_commit;
    logic              new_commit;
    logic              eof_chk;
    logic              ghost_mul;
    logic              ghost_emit;
    logic              flush;
    logic              eof_done;
    logic [CNT_W-1:0]  keep_cnt;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             best_valid;
    logic [IDX_W-1:0] best_idx;
    logic             out_free;
    logic             keep_ok;
    logic             ghost;
    logic             pend_valid;
  } stat_t;

  function automatic logic signed [COORD_BITS-1:0] round_pos(input logic signed [GS_W-1:0] v);
    logic signed [GS_W-1:0] r;
    r = (v + GS_HALF) >>> FRAC_BITS;
    if (r > POS_MAX) begin
      r = POS_MAX;
    end else if (r < POS_MIN) begin
      r = POS_MIN;
    end
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [DIM_BITS-1:0] round_dim(input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] r;
    r = ({1'b0, s} + SIZE_HALF) >> FRAC_BITS;
    if (r > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r[DIM_BITS-1:0];
  endfunction

endpackage

// ===== sv/itm_ctrl.sv =====
module itm_ctrl import itm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_func,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'd1,
    S_SCAN   = 13'd2,
    S_DRAIN  = 13'd4,
    S_DECIDE = 13'd8,
    S_MRD    = 13'd16,
    S_EMA    = 13'd32,
    S_MWR    = 13'd64,
    S_NWR    = 13'd128,
    S_ERD    = 13'd256,
    S_ECHK   = 13'd512,
    S_EMUL   = 13'd1024,
    S_EGH    = 13'd2048,
    S_EFLUSH = 13'd4096
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  keepc, keepc_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      keepc <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      keepc <= keepc_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    keepc_next   = keepc;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.addr     = idx[IDX_W-1:0];
    cmd.ema_step = cnt;
    cmd.keep_cnt = keepc;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc  = 1'b1;
          idx_next = '0;
          if (in_func) begin
            keepc_next = '0;
            state_next = S_ERD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx == stat.count) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cmd.scan_rd = 1'b1;
          idx_next    = idx + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (cnt == STEP_W'(DRAIN_CYC - 1)) begin
          state_next = S_DECIDE;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_DECIDE: begin
        state_next = stat.best_valid ? S_MRD : S_NWR;
      end
      S_MRD: begin
        cmd.rd     = 1'b1;
        cmd.addr   = stat.best_idx;
        cnt_next   = '0;
        state_next = S_EMA;
      end
      S_EMA: begin
        cmd.ema_en = 1'b1;
        if (cnt == STEP_W'(EMA_OPS)) begin
          state_next = S_MWR;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_MWR: begin
        if (stat.out_free) begin
          cmd.match_commit = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_NWR: begin
        if (stat.out_free) begin
          cmd.new_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_ERD: begin
        if (idx == stat.count) begin
          state_next = S_EFLUSH;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_ECHK;
        end
      end
      S_ECHK: begin
        cmd.eof_chk = 1'b1;
        if (stat.keep_ok) begin
          keepc_next = keepc + CNT_W'(1);
        end
        if (stat.ghost) begin
          state_next = S_EMUL;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_ERD;
        end
      end
      S_EMUL: begin
        cmd.ghost_mul = 1'b1;
        state_next    = S_EGH;
      end
      S_EGH: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.ghost_emit = 1'b1;
          idx_next       = idx + CNT_W'(1);
          state_next     = S_ERD;
        end
      end
      S_EFLUSH: begin
        if (!stat.pend_valid) begin
          cmd.eof_done = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush    = 1'b1;
          cmd.eof_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/itm_dp.sv =====
module itm_dp import itm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic [LABEL_W-1:0]           in_label,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic [DIM_BITS-1:0]          in_w,
  input  logic [DIM_BITS-1:0]          in_h,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [DIM_BITS-1:0]          out_w,
  output logic [DIM_BITS-1:0]          out_h,
  output logic [LABEL_W-1:0]           out_label,
  output logic [1:0]                   kind,
  output logic                         last,
  input  cmd_t                         cmd,
  output stat_t                        stat
);

  // configuration
  logic [ALPHA_W-1:0] alpha, thr;
  logic [MISS_W-1:0]  max_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= ALPHA_RST;
      thr      <= THR_RST;
      max_miss <= MISS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA:   alpha <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
        CFG_IOU:     thr <= cfg_data;
        CFG_MAXMISS: max_miss <= cfg_data[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured detection
  logic [LABEL_W-1:0]           lab_r;
  logic signed [COORD_BITS-1:0] bx_r, by_r;
  logic [DIM_BITS-1:0]          bw_r, bh_r;
  logic [AREA_W-1:0]            area_d;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      lab_r  <= in_label;
      bx_r   <= in_x;
      by_r   <= in_y;
      bw_r   <= in_w;
      bh_r   <= in_h;
      area_d <= AREA_W'(in_w) * AREA_W'(in_h);
    end
  end

  // track table
  track_t           mem [MAX_TRACKS];
  track_t           rdata, wdata, upd_rec, new_rec, aged_rec;
  logic             we;
  logic [IDX_W-1:0] waddr, ridx;
  logic [CNT_W-1:0] count;
  logic [MAX_TRACKS-1:0] new_f, match_f;
  logic             full;
  logic             rd_en;

  assign rd_en = cmd.rd || cmd.scan_rd;
  assign full  = (count == CNT_W'(MAX_TRACKS));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[cmd.addr];
      ridx  <= cmd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      new_f   <= '0;
      match_f <= '0;
    end else begin
      if (cmd.new_commit && !full) begin
        count                   <= count + CNT_W'(1);
        new_f[count[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.match_commit) begin
        match_f[ridx] <= 1'b1;
      end
      if (cmd.eof_done) begin
        count   <= cmd.keep_cnt;
        new_f   <= '0;
        match_f <= '0;
      end
    end
  end

  // overlap scan pipeline
  logic                         v1, v2, v3, v4, v5;
  logic [IDX_W-1:0]             idx2, idx3, idx4, idx5;
  logic                         elig1;
  logic signed [COORD_BITS-1:0] x1, y1;
  logic signed [COORD_BITS:0]   xe_d, ye_d, xe_t, ye_t, x2, y2;
  logic signed [COORD_BITS+1:0] ovx, ovy;
  logic [DIM_BITS-1:0]          ow2, oh2, tw2, th2;
  logic [AREA_W-1:0]            inter3, areat3, inter4, inter5;
  logic [UNI_W-1:0]             uni4, uni5;
  logic [THR_W-1:0]             thr_lhs, thr_rhs;
  logic [CMP_W-1:0]             cmp_new, cmp_best;
  logic                         best_valid;
  logic [IDX_W-1:0]             best_idx;
  logic [AREA_W-1:0]            best_i;
  logic [UNI_W-1:0]             best_u;

  always_comb begin
    elig1 = !new_f[ridx] && !match_f[ridx] && (rdata.label == lab_r);
    x1    = (bx_r > rdata.bx) ? bx_r : rdata.bx;
    y1    = (by_r > rdata.by) ? by_r : rdata.by;
    xe_d  = (COORD_BITS + 1)'(bx_r) + (COORD_BITS + 1)'($signed({1'b0, bw_r}));
    ye_d  = (COORD_BITS + 1)'(by_r) + (COORD_BITS + 1)'($signed({1'b0, bh_r}));
    xe_t  = (COORD_BITS + 1)'(rdata.bx) + (COORD_BITS + 1)'($signed({1'b0, rdata.bw}));
    ye_t  = (COORD_BITS + 1)'(rdata.by) + (COORD_BITS + 1)'($signed({1'b0, rdata.bh}));
    x2    = (xe_d < xe_t) ? xe_d : xe_t;
    y2    = (ye_d < ye_t) ? ye_d : ye_t;
    ovx   = (COORD_BITS + 2)'(x2) - (COORD_BITS + 2)'(x1);
    ovy   = (COORD_BITS + 2)'(y2) - (COORD_BITS + 2)'(y1);
  end

  assign thr_lhs  = THR_W'({inter4, {Q_BITS{1'b0}}});
  assign thr_rhs  = THR_W'(thr) * THR_W'(uni4);
  assign cmp_new  = CMP_W'(inter5) * CMP_W'(best_u);
  assign cmp_best = CMP_W'(best_i) * CMP_W'(uni5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1 && elig1 && !ovx[COORD_BITS+1] && !ovy[COORD_BITS+1];
      v3 <= v2;
      v4 <= v3 && (inter3 != '0);
      v5 <= v4 && (thr_lhs > thr_rhs);
    end
  end

  always_ff @(posedge clk) begin
    ow2    <= ovx[DIM_BITS-1:0];
    oh2    <= ovy[DIM_BITS-1:0];
    tw2    <= rdata.bw;
    th2    <= rdata.bh;
    idx2   <= ridx;
    inter3 <= AREA_W'(ow2) * AREA_W'(oh2);
    areat3 <= AREA_W'(tw2) * AREA_W'(th2);
    idx3   <= idx2;
    uni4   <= UNI_W'(area_d) + UNI_W'(areat3) - UNI_W'(inter3);
    inter4 <= inter3;
    idx4   <= idx3;
    uni5   <= uni4;
    inter5 <= inter4;
    idx5   <= idx4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      best_valid <= 1'b0;
    end else if (v5 && (cmp_new > cmp_best)) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_i <= '0;
      best_u <= UNI_W'(1);
    end else if (v5 && (cmp_new > cmp_best)) begin
      best_idx <= idx5;
      best_i   <= inter5;
      best_u   <= uni5;
    end
  end

  // smoothing unit, one multiply per operation
  logic signed [EMA_W-1:0]  dx, dy, dw, dh, e_old, e_meas, e_old_r, e_res;
  logic signed [EMA_W:0]    e_diff;
  logic signed [PROD_W-1:0] e_prod, e_sh;
  logic                     e_v;
  logic [STEP_W-1:0]        e_op;
  logic signed [EMA_W-1:0]  nvx, nvy, npx, npy, nsw, nsh;

  assign dx = EMA_W'(bx_r) <<< FRAC_BITS;
  assign dy = EMA_W'(by_r) <<< FRAC_BITS;
  assign dw = $signed(EMA_W'(bw_r)) <<< FRAC_BITS;
  assign dh = $signed(EMA_W'(bh_r)) <<< FRAC_BITS;

  always_comb begin
    case (cmd.ema_step)
      EOP_VX: begin
        e_old  = EMA_W'(rdata.vx);
        e_meas = dx - EMA_W'(rdata.px);
      end
      EOP_VY: begin
        e_old  = EMA_W'(rdata.vy);
        e_meas = dy - EMA_W'(rdata.py);
      end
      EOP_PX: begin
        e_old  = EMA_W'(rdata.px);
        e_meas = dx;
      end
      EOP_PY: begin
        e_old  = EMA_W'(rdata.py);
        e_meas = dy;
      end
      EOP_SW: begin
        e_old  = $signed(EMA_W'(rdata.sw));
        e_meas = dw;
      end
      EOP_SH: begin
        e_old  = $signed(EMA_W'(rdata.sh));
        e_meas = dh;
      end
      default: begin
        e_old  = '0;
        e_meas = '0;
      end
    endcase
    e_diff = (EMA_W + 1)'(e_meas) - (EMA_W + 1)'(e_old);
    e_sh   = (e_prod + PROD_HALF) >>> Q_BITS;
    e_res  = e_old_r + EMA_W'(e_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= cmd.ema_en && (cmd.ema_step < STEP_W'(EMA_OPS));
    end
  end

  always_ff @(posedge clk) begin
    e_prod  <= PROD_W'(e_diff) * PROD_W'($signed({1'b0, alpha}));
    e_old_r <= e_old;
    e_op    <= cmd.ema_step;
    if (e_v) begin
      case (e_op)
        EOP_VX:  nvx <= e_res;
        EOP_VY:  nvy <= e_res;
        EOP_PX:  npx <= e_res;
        EOP_PY:  npy <= e_res;
        EOP_SW:  nsw <= e_res;
        EOP_SH:  nsh <= e_res;
        default: ;
      endcase
    end
  end

  // end of frame aging and ghost
  logic [MISS_W:0]         m5;
  logic                    elig_e, keep_ok;
  logic signed [GP_W-1:0]  gpx, gpy;
  logic signed [GS_W-1:0]  gsx, gsy;

  assign m5      = {1'b0, rdata.miss} + (MISS_W + 1)'(1);
  assign elig_e  = !new_f[ridx] && !match_f[ridx];
  assign keep_ok = !elig_e || (m5 <= {1'b0, max_miss});
  assign gsx     = GS_W'(rdata.px) + GS_W'(gpx);
  assign gsy     = GS_W'(rdata.py) + GS_W'(gpy);

  always_ff @(posedge clk) begin
    if (cmd.ghost_mul) begin
      gpx <= GP_W'(rdata.vx) * GP_W'($signed({1'b0, m5}));
      gpy <= GP_W'(rdata.vy) * GP_W'($signed({1'b0, m5}));
    end
  end

  // record images for write-back
  always_comb begin
    upd_rec      = rdata;
    upd_rec.bx   = bx_r;
    upd_rec.by   = by_r;
    upd_rec.bw   = bw_r;
    upd_rec.bh   = bh_r;
    upd_rec.px   = POS_W'(npx);
    upd_rec.py   = POS_W'(npy);
    upd_rec.sw   = SIZE_W'(nsw);
    upd_rec.sh   = SIZE_W'(nsh);
    upd_rec.vx   = VEL_W'(nvx);
    upd_rec.vy   = VEL_W'(nvy);
    upd_rec.miss = '0;

    new_rec.label = lab_r;
    new_rec.bx    = bx_r;
    new_rec.by    = by_r;
    new_rec.bw    = bw_r;
    new_rec.bh    = bh_r;
    new_rec.px    = POS_W'(dx);
    new_rec.py    = POS_W'(dy);
    new_rec.sw    = SIZE_W'(dw);
    new_rec.sh    = SIZE_W'(dh);
    new_rec.vx    = '0;
    new_rec.vy    = '0;
    new_rec.miss  = '0;

    aged_rec      = rdata;
    if (elig_e) begin
      aged_rec.miss = m5[MISS_W-1:0];
    end

    we    = 1'b0;
    waddr = ridx;
    wdata = rdata;
    if (cmd.match_commit) begin
      we    = 1'b1;
      wdata = upd_rec;
    end else if (cmd.new_commit && !full) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = new_rec;
    end else if (cmd.eof_chk && keep_ok) begin
      we    = 1'b1;
      waddr = cmd.keep_cnt[IDX_W-1:0];
      wdata = aged_rec;
    end
  end

  // pending ghost, held back until the next one shows whether it is the last
  logic                         p_valid;
  logic signed [COORD_BITS-1:0] p_x, p_y;
  logic [DIM_BITS-1:0]          p_w, p_h;
  logic [LABEL_W-1:0]           p_label;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.ghost_emit) begin
      p_valid <= 1'b1;
    end else if (cmd.flush) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ghost_emit) begin
      p_x     <= round_pos(gsx);
      p_y     <= round_pos(gsy);
      p_w     <= round_dim(rdata.sw);
      p_h     <= round_dim(rdata.sh);
      p_label <= rdata.label;
    end
  end

  // output register
  logic                         o_load;
  logic signed [COORD_BITS-1:0] o_x, o_y;
  logic [DIM_BITS-1:0]          o_w, o_h;
  logic [LABEL_W-1:0]           o_label;
  kind_t                        o_kind;
  logic                         o_last;

  always_comb begin
    o_load  = 1'b0;
    o_x     = p_x;
    o_y     = p_y;
    o_w     = p_w;
    o_h     = p_h;
    o_label = p_label;
    o_kind  = KIND_GHOST;
    o_last  = 1'b0;
    if (cmd.match_commit) begin
      o_load  = 1'b1;
      o_x     = round_pos(GS_W'(npx));
      o_y     = round_pos(GS_W'(npy));
      o_w     = round_dim(SIZE_W'(nsw));
      o_h     = round_dim(SIZE_W'(nsh));
      o_label = lab_r;
      o_kind  = KIND_MATCH;
      o_last  = 1'b1;
    end else if (cmd.new_commit) begin
      o_load  = 1'b1;
      o_x     = bx_r;
      o_y     = by_r;
      o_w     = bw_r;
      o_h     = bh_r;
      o_label = lab_r;
      o_kind  = full ? KIND_UNTRACKED : KIND_NEW;
      o_last  = 1'b1;
    end else if (cmd.ghost_emit && p_valid) begin
      o_load = 1'b1;
    end else if (cmd.flush) begin
      o_load = 1'b1;
      o_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_x     <= o_x;
      out_y     <= o_y;
      out_w     <= o_w;
      out_h     <= o_h;
      out_label <= o_label;
      kind      <= o_kind;
      last      <= o_last;
    end
  end

  always_comb begin
    stat.count      = count;
    stat.best_valid = best_valid;
    stat.best_idx   = best_idx;
    stat.out_free   = !out_valid || !out_stall;
    stat.keep_ok    = keep_ok;
    stat.ghost      = elig_e && keep_ok;
    stat.pend_valid = p_valid;
  end

endmodule

// ===== sv/iou_track_matcher_ema.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+-----------------------------------------
// input     | in_valid / in_stall         | func, label, box_x, box_y, box_w, box_h
// output    | out_valid / out_stall       | out_x, out_y, out_w, out_h, out_label,
//           |                             | kind, last
// config    | cfg_we (no wait)            | cfg_index, cfg_data
//
// one transaction in flight; a detection is scanned against every live track, then
// smoothed and written back when it matches, or it opens a track or comes back untracked
// (one table read per cycle through the overlap pipeline, then six smoothing multiplies
// on a match); end of frame reads each track to age, drop or keep it, and emits ghosts
// the table is one memory read and written a record at a time
// rst is synchronous; it empties the table and restores the register defaults
// a stalled result waits in the output register while the next transaction is taken
module iou_track_matcher_ema import itm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // input transactions
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [LABEL_W-1:0]           label,
  input  logic signed [COORD_BITS-1:0] box_x,
  input  logic signed [COORD_BITS-1:0] box_y,
  input  logic [DIM_BITS-1:0]          box_w,
  input  logic [DIM_BITS-1:0]          box_h,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [DIM_BITS-1:0]          out_w,
  output logic [DIM_BITS-1:0]          out_h,
  output logic [LABEL_W-1:0]           out_label,
  output logic [1:0]                   kind,
  output logic                         last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: scan, smoothing steps and the frame-end walk
  itm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // track memory, overlap pipeline, smoothing multiplier, result register
  itm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_label  (label),
    .in_x      (box_x),
    .in_y      (box_y),
    .in_w      (box_w),
    .in_h      (box_h),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_w     (out_w),
    .out_h     (out_h),
    .out_label (out_label),
    .kind      (kind),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== sv/itm_checker.sv =====
module itm_checker import itm_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_x,
  input logic signed [COORD_BITS-1:0] out_y,
  input logic [DIM_BITS-1:0]          out_w,
  input logic [DIM_BITS-1:0]          out_h,
  input logic [LABEL_W-1:0]           out_label,
  input logic [1:0]                   kind,
  input logic                         last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({out_x, out_y, out_w, out_h, out_label, kind, last}))
    else $error("stalled result changed");

  // a detection gives exactly one result, so it always closes its group
  a_det_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_GHOST) |-> last)
    else $error("detection result without last");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // a new result only comes out of a busy block
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind iou_track_matcher_ema itm_checker u_itm_checker (.*);
